// ===== rtl/jdcd_pkg.sv =====
package jdcd_pkg;

  // register stages from input to output register
  localparam int DEPTH       = 15;
  // last register stage of the Gregorian and Julian front ends
  localparam int FRONT_STAGE = 9;
  // stage at which the weekday is final
  localparam int WDAY_STAGE  = 3;

  localparam logic [23:0] GREG_START = 24'd2299161;
  localparam int MONTH_SCALE = 2447;

  typedef logic [DEPTH-1:0] stage_en_t;

  // day count from 1 March style origin plus year base, handed to the tail
  typedef struct packed {
    logic [8:0]  days;
    logic [16:0] yr_base;
  } front_t;

  // floor(2447 * m / 80)
  function automatic logic [8:0] month_start(input logic [3:0] m);
    case (m)
      4'd0:    month_start = 9'd0;
      4'd1:    month_start = 9'd30;
      4'd2:    month_start = 9'd61;
      4'd3:    month_start = 9'd91;
      4'd4:    month_start = 9'd122;
      4'd5:    month_start = 9'd152;
      4'd6:    month_start = 9'd183;
      4'd7:    month_start = 9'd214;
      4'd8:    month_start = 9'd244;
      4'd9:    month_start = 9'd275;
      4'd10:   month_start = 9'd305;
      4'd11:   month_start = 9'd336;
      4'd12:   month_start = 9'd367;
      default: month_start = 9'd0;
    endcase
  endfunction

endpackage

// ===== rtl/jdcd_greg.sv =====
module jdcd_greg (
  input  logic                clk,
  input  jdcd_pkg::stage_en_t en,
  input  logic [23:0]         julian_day,
  output logic                greg,
  output jdcd_pkg::front_t    res
);
  import jdcd_pkg::*;

  localparam int DAYS_400Y  = 146097;
  localparam int YEAR_SCALE = 1461001;
  localparam int DAYS_4Y    = 1461;
  localparam int CENT_K     = 27;
  localparam int YEAR_K     = 28;
  // floor reciprocals: estimate is exact or one low
  localparam logic [9:0] CENT_RCP = 10'((1 << CENT_K) / DAYS_400Y);
  localparam logic [7:0] YEAR_RCP = 8'((1 << YEAR_K) / YEAR_SCALE);

  logic [26:0] x0, x1, x2;
  logic        g0, g1, g2, g3, g4, g5, g6, g7, g8;
  logic [8:0]  ce1, ce2;
  logic [26:0] cb2;
  logic [8:0]  cent3, cent4, cent5, cent6, cent7;
  logic [15:0] a1_3, a1_4, a1_5, a1_6, a1_7, a1_8;
  logic [27:0] yx4, yx5, yx6;
  logic [6:0]  y5, y6, y7, y8;
  logic [27:0] yb6;
  logic [17:0] p8;
  logic [15:0] c100_8;

  logic [36:0] ce_prod;
  logic [35:0] y_prod;
  logic [18:0] crem;
  logic        ccorr;
  logic [21:0] yrem;

  assign ce_prod = 37'(x0) * 37'(CENT_RCP);
  assign y_prod  = 36'(yx4) * 36'(YEAR_RCP);
  assign crem    = 19'(x2 - cb2);
  assign ccorr   = crem >= 19'(DAYS_400Y);
  assign yrem    = 22'(yx6 - yb6);

  always_ff @(posedge clk) begin
    if (en[0]) begin
      x0 <= {25'(julian_day) + 25'd68569, 2'b00};
      g0 <= julian_day >= GREG_START;
    end
    if (en[1]) begin
      ce1 <= ce_prod[CENT_K +: 9];
      x1  <= x0;
      g1  <= g0;
    end
    if (en[2]) begin
      cb2 <= 27'(27'(ce1) * 27'(DAYS_400Y));
      ce2 <= ce1;
      x2  <= x1;
      g2  <= g1;
    end
    if (en[3]) begin
      // a = a0 - (146097*cent + 3)/4 reduces to remainder / 4
      cent3 <= ce2 + 9'(ccorr);
      a1_3  <= 16'((ccorr ? crem - 19'(DAYS_400Y) : crem) >> 2);
      g3    <= g2;
    end
    if (en[4]) begin
      yx4   <= (28'(a1_3) + 28'd1) * 28'd4000;
      cent4 <= cent3;
      a1_4  <= a1_3;
      g4    <= g3;
    end
    if (en[5]) begin
      y5    <= y_prod[YEAR_K +: 7];
      yx5   <= yx4;
      cent5 <= cent4;
      a1_5  <= a1_4;
      g5    <= g4;
    end
    if (en[6]) begin
      yb6   <= 28'(28'(y5) * 28'(YEAR_SCALE));
      y6    <= y5;
      yx6   <= yx5;
      cent6 <= cent5;
      a1_6  <= a1_5;
      g6    <= g5;
    end
    if (en[7]) begin
      y7    <= y6 + 7'(yrem >= 22'(YEAR_SCALE));
      cent7 <= cent6;
      a1_7  <= a1_6;
      g7    <= g6;
    end
    if (en[8]) begin
      p8     <= 18'(18'(y7) * 18'(DAYS_4Y));
      c100_8 <= 16'(16'(cent7) * 16'd100);
      y8     <= y7;
      a1_8   <= a1_7;
      g8     <= g7;
    end
    if (en[FRONT_STAGE]) begin
      res.days    <= 9'(a1_8 + 16'd31 - 16'(p8 >> 2));
      res.yr_base <= 17'(c100_8) - 17'd4900 + 17'(y8);
      greg        <= g8;
    end
  end

endmodule

// ===== rtl/jdcd_jul.sv =====
module jdcd_jul (
  input  logic                clk,
  input  jdcd_pkg::stage_en_t en,
  input  logic [23:0]         julian_day,
  output jdcd_pkg::front_t    res
);
  import jdcd_pkg::*;

  localparam int DAYS_4Y = 1461;
  localparam int QUAD_K  = 25;
  localparam logic [14:0] QUAD_RCP = 15'((1 << QUAD_K) / DAYS_4Y);

  logic [24:0] xj0, xj1, xj2;
  logic [13:0] q1, q2, quad3, quad4;
  logic [24:0] qb2;
  logic [10:0] rf3, rf4;
  logic [1:0]  ny4;
  front_t      fr [5:FRONT_STAGE];

  logic [39:0] q_prod;
  logic [11:0] qrem;
  logic        qcorr;

  assign q_prod = 40'(xj0) * 40'(QUAD_RCP);
  assign qrem   = 12'(xj2 - qb2);
  assign qcorr  = qrem >= 12'(DAYS_4Y);
  assign res    = fr[FRONT_STAGE];

  always_ff @(posedge clk) begin
    if (en[0]) begin
      xj0 <= 25'(julian_day) + 25'd1401;
    end
    if (en[1]) begin
      q1  <= q_prod[QUAD_K +: 14];
      xj1 <= xj0;
    end
    if (en[2]) begin
      qb2 <= 25'(25'(q1) * 25'(DAYS_4Y));
      q2  <= q1;
      xj2 <= xj1;
    end
    if (en[3]) begin
      quad3 <= q2 + 14'(qcorr);
      rf3   <= 11'(qcorr ? qrem - 12'(DAYS_4Y) : qrem);
    end
    if (en[4]) begin
      // last day of a leap cycle stays in year three
      ny4   <= 2'(rf3 >= 11'd365) + 2'(rf3 >= 11'd730) + 2'(rf3 >= 11'd1095);
      rf4   <= rf3;
      quad4 <= quad3;
    end
    if (en[5]) begin
      fr[5].days    <= 9'(rf4 + 11'd31 - 11'(11'(ny4) * 11'd365));
      fr[5].yr_base <= 17'({quad4, 2'b00}) + 17'(ny4) - 17'd4716;
    end
    for (int k = 6; k <= FRONT_STAGE; k++) begin
      if (en[k]) begin
        fr[k] <= fr[k-1];
      end
    end
  end

endmodule

// ===== rtl/jdcd_wday.sv =====
module jdcd_wday (
  input  logic                clk,
  input  jdcd_pkg::stage_en_t en,
  input  logic [23:0]         julian_day,
  output logic [2:0]          weekday
);
  import jdcd_pkg::*;

  localparam int WK_K = 25;
  localparam logic [22:0] WK_RCP = 23'((1 << WK_K) / 7);

  logic [24:0] xw0, xw1, xw2;
  logic [21:0] w1;
  logic [24:0] wb2;
  logic [2:0]  wd [WDAY_STAGE:DEPTH-1];

  logic [47:0] w_prod;
  logic [3:0]  wrem;

  assign w_prod  = 48'(xw0) * 48'(WK_RCP);
  assign wrem    = 4'(xw2 - wb2);
  assign weekday = wd[DEPTH-1];

  always_ff @(posedge clk) begin
    if (en[0]) begin
      xw0 <= 25'(julian_day) + 25'd2;
    end
    if (en[1]) begin
      w1  <= w_prod[WK_K +: 22];
      xw1 <= xw0;
    end
    if (en[2]) begin
      wb2 <= 25'(25'(w1) * 25'd7);
      xw2 <= xw1;
    end
    if (en[WDAY_STAGE]) begin
      wd[WDAY_STAGE] <= 3'((wrem >= 4'd7) ? wrem - 4'd7 : wrem);
    end
    for (int k = WDAY_STAGE + 1; k < DEPTH; k++) begin
      if (en[k]) begin
        wd[k] <= wd[k-1];
      end
    end
  end

endmodule

// ===== rtl/jdcd_tail.sv =====
module jdcd_tail (
  input  logic                clk,
  input  jdcd_pkg::stage_en_t en,
  input  logic                greg,
  input  jdcd_pkg::front_t    g_res,
  input  jdcd_pkg::front_t    j_res,
  output logic [4:0]          day_of_month,
  output logic [3:0]          month,
  output logic signed [16:0]  year
);
  import jdcd_pkg::*;

  localparam int MON_K = 16;
  localparam logic [4:0] MON_RCP = 5'((1 << MON_K) / MONTH_SCALE);

  logic [8:0]  a10, a11, a12, a13;
  logic [16:0] yb10, yb11, yb12, yb13;
  logic [15:0] mx10, mx11, mx12;
  logic [3:0]  m11, m12, m13;
  logic [15:0] mb12;

  front_t      sel;
  logic [20:0] m_prod;
  logic [15:0] mrem;
  logic        t;

  assign sel    = greg ? g_res : j_res;
  assign m_prod = 21'(mx10) * 21'(MON_RCP);
  assign mrem   = mx12 - mb12;
  assign t      = m13 >= 4'd11;

  always_ff @(posedge clk) begin
    if (en[10]) begin
      a10  <= sel.days;
      yb10 <= sel.yr_base;
      mx10 <= 16'(16'(sel.days) * 16'd80);
    end
    if (en[11]) begin
      m11  <= m_prod[MON_K +: 4];
      mx11 <= mx10;
      a11  <= a10;
      yb11 <= yb10;
    end
    if (en[12]) begin
      mb12 <= 16'(16'(m11) * 16'(MONTH_SCALE));
      m12  <= m11;
      mx12 <= mx11;
      a12  <= a11;
      yb12 <= yb11;
    end
    if (en[13]) begin
      m13  <= m12 + 4'(mrem >= 16'(MONTH_SCALE));
      a13  <= a12;
      yb13 <= yb12;
    end
    if (en[DEPTH-1]) begin
      day_of_month <= 5'(a13 - month_start(m13));
      month        <= t ? m13 - 4'd10 : m13 + 4'd2;
      year         <= $signed(yb13 + 17'(t));
    end
  end

endmodule

// ===== rtl/julian_day_to_calendar_date.sv =====
// Julian day number to calendar date.
//
// Input channel: julian_day with jd_valid / jd_ready. Output channel:
// day_of_month, month, year (astronomical, two's complement) and weekday
// with date_valid / date_ready. An item moves when valid and ready are
// both high at a rising clock edge.
//
// Day numbers from 2299161 up use the Gregorian calendar, lower ones the
// Julian calendar. All divisions by constants but those by four are reciprocal
// multiplies with a one-step remainder correction; division by four is a shift.
//
// There are 15 register stages; while date_ready is high the block takes
// one item per cycle.
// Each stage has its own valid bit and loads whenever it is empty or the
// stage after it moves, so a stalled receiver holds the result in the
// output register while earlier stages keep filling bubbles; jd_ready
// drops only once every stage holds an item.
// Reset (rst, synchronous) clears all valid bits; no data is cleared.
module julian_day_to_calendar_date (
  input  logic               clk,
  input  logic               rst,
  input  logic               jd_valid,
  output logic               jd_ready,
  input  logic [23:0]        julian_day,
  output logic               date_valid,
  input  logic               date_ready,
  output logic [4:0]         day_of_month,
  output logic [3:0]         month,
  output logic signed [16:0] year,
  output logic [2:0]         weekday
);
  import jdcd_pkg::*;

  stage_en_t vld;
  stage_en_t en;
  logic      greg;
  front_t    g_res;
  front_t    j_res;

  // stage k moves when the output moves or some stage from k on is empty
  always_comb begin
    for (int k = 0; k < DEPTH; k++) begin
      en[k] = date_ready | ~&(vld | ((stage_en_t'(1) << k) - stage_en_t'(1)));
    end
  end

  assign jd_ready   = en[0];
  assign date_valid = vld[DEPTH-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) begin
        vld[0] <= jd_valid;
      end
      for (int k = 1; k < DEPTH; k++) begin
        if (en[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  jdcd_greg u_greg (
    .clk        (clk),
    .en         (en),
    .julian_day (julian_day),
    .greg       (greg),
    .res        (g_res)
  );

  jdcd_jul u_jul (
    .clk        (clk),
    .en         (en),
    .julian_day (julian_day),
    .res        (j_res)
  );

  jdcd_wday u_wday (
    .clk        (clk),
    .en         (en),
    .julian_day (julian_day),
    .weekday    (weekday)
  );

  jdcd_tail u_tail (
    .clk          (clk),
    .en           (en),
    .greg         (greg),
    .g_res        (g_res),
    .j_res        (j_res),
    .day_of_month (day_of_month),
    .month        (month),
    .year         (year)
  );

endmodule
